/* sv/phb_pkg.sv */
// types and constants shared by the plcp transmit header builder
package phb_pkg;

    // input frame descriptor
    typedef struct packed {
        logic [11:0] frame_length;
        logic [7:0]  crypto_overhead;
        logic [9:0]  bitrate;
        logic [3:0]  ofdm_rate_code;
    } req_t;

    // plcp header result
    typedef struct packed {
        logic        is_ofdm;
        logic [3:0]  ofdm_rate_field;
        logic [12:0] ofdm_length;
        logic [7:0]  cck_signal;
        logic [15:0] cck_length_us;
        logic        cck_length_ext;
        logic        cck_clock_locked;
        logic [10:0] header_words;
        logic        rate_unknown;
    } res_t;

    // cck rates in 100 kbit/s units
    localparam logic [9:0] RATE_1M   = 10'd10;
    localparam logic [9:0] RATE_2M   = 10'd20;
    localparam logic [9:0] RATE_5M5  = 10'd55;
    localparam logic [9:0] RATE_11M  = 10'd110;

    localparam logic [2:0] FCS_BYTES = 3'd4;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for any 10-bit x
    localparam logic [9:0]  DIV3_MUL   = 10'd683;
    localparam int          DIV3_SHIFT = 11;

    // floor(x / 11) = (x * DIV11_MUL) >> DIV11_SHIFT for x below 2**17
    localparam logic [17:0] DIV11_MUL   = 18'd190651;
    localparam int          DIV11_SHIFT = 21;

    localparam logic [3:0]  ROUND_US   = 4'd10;

endpackage

/* sv/phb_stream_if.sv */
// valid/ready channel carrying one payload struct
interface phb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

/* sv/phb_calc.sv */
// combinational plcp header computation for one frame descriptor
module phb_calc #(
    parameter int TX_HDR_BYTES = 8
) (
    input  phb_pkg::req_t d,
    output phb_pkg::res_t r
);
    import phb_pkg::*;

    localparam int WSUM_MAX = 4095 + 255 + TX_HDR_BYTES + 3;
    localparam int WSUM_W   = $clog2(WSUM_MAX + 1);

    logic [12:0]         plcp;
    logic [19:0]         div3_prod;
    logic [8:0]          quot3;
    logic [9:0]          rem3;
    logic                ofdm;
    logic [16:0]         numer;
    logic [34:0]         div11_prod;
    logic [13:0]         quot11;
    logic [17:0]         quot11_x11;
    logic [17:0]         plcp_x8_p8;
    logic [15:0]         us;
    logic                ext;
    logic                unk;
    logic [WSUM_W-1:0]   wsum;

    assign plcp = 13'(d.frame_length) + 13'(FCS_BYTES) + 13'(d.crypto_overhead);

    // rate mod 3 via reciprocal multiply
    assign div3_prod = 20'(d.bitrate) * 20'(DIV3_MUL);
    assign quot3     = div3_prod[19:DIV3_SHIFT];
    assign rem3      = d.bitrate - (10'(quot3) * 10'd3);
    assign ofdm      = (rem3 == 10'd0);

    // one shared divide by 11 for both 5.5 and 11 mbit/s
    assign numer      = (d.bitrate == RATE_5M5) ? ({plcp, 4'b0000} + 17'(ROUND_US))
                                                : ({1'b0, plcp, 3'b000} + 17'(ROUND_US));
    assign div11_prod = 35'(numer) * 35'(DIV11_MUL);
    assign quot11     = div11_prod[34:DIV11_SHIFT];

    // length extension when floor(11*us/8) > plcp, i.e. 11*us >= 8*plcp + 8
    assign quot11_x11 = {quot11, 3'b000} + {3'b000, quot11, 1'b0} + {4'b0000, quot11};
    assign plcp_x8_p8 = {2'b00, plcp, 3'b000} + 18'd8;

    always_comb
    begin
        us  = '0;
        ext = 1'b0;
        unk = 1'b0;
        if (!ofdm)
        begin
            unique case (d.bitrate)
                RATE_1M:  us = {plcp, 3'b000};
                RATE_2M:  us = {1'b0, plcp, 2'b00};
                RATE_5M5: us = 16'(quot11);
                RATE_11M:
                begin
                    us  = 16'(quot11);
                    ext = (quot11_x11 >= plcp_x8_p8);
                end
                default:  unk = 1'b1;
            endcase
        end
    end

    assign wsum = WSUM_W'(d.frame_length) + WSUM_W'(d.crypto_overhead)
                + WSUM_W'(TX_HDR_BYTES) + WSUM_W'(3);

    always_comb
    begin
        r.is_ofdm          = ofdm;
        r.ofdm_rate_field  = ofdm ? d.ofdm_rate_code : 4'd0;
        r.ofdm_length      = ofdm ? plcp : 13'd0;
        r.cck_signal       = ofdm ? 8'd0 : d.bitrate[7:0];
        r.cck_length_us    = us;
        r.cck_length_ext   = ext;
        r.cck_clock_locked = !ofdm;
        r.header_words     = 11'(wsum >> 2);
        r.rate_unknown     = unk;
    end
endmodule

/* sv/plcp_tx_header_builder.sv */
// top level of the plcp transmit header builder
//
// one frame descriptor enters on req (frame_length, crypto_overhead, bitrate,
// ofdm_rate_code) and exactly one plcp header result leaves on res, in order.
// a request is taken at a rising edge with valid and ready both high.
// the descriptor is captured in an input register, the header fields are
// computed in one pass of logic (one divide-by-11 multiplier shared by the
// 5.5 and 11 mbit/s paths) and captured in the result register.
// the result is valid on res once it is captured in the result register.
// throughput: one request per cycle, sustained, as long as res.ready is high.
// when the receiver stalls, the result register holds its value and the input
// register can still take one more request; req.ready drops only when both
// registers are full and res.ready is low.
// reset (rst_n low, asynchronous) empties both registers; no item is lost or
// invented afterwards and no setup is needed before the first request.
// TX_HDR_BYTES is the descriptor header size added into header_words.
module plcp_tx_header_builder #(
    parameter int TX_HDR_BYTES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    phb_stream_if.sink        req,
    phb_stream_if.source      res
);
    import phb_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    req_t  in_data_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_data_reg;
    res_t  calc_res;
    logic  advance;
    logic  take;

    phb_calc #(
        .TX_HDR_BYTES (TX_HDR_BYTES)
    ) u_calc (
        .d (in_data_reg),
        .r (calc_res)
    );

    // result register frees up when empty or being drained
    assign advance   = !out_valid_reg || res.ready;
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign in_valid_next  = req.ready ? req.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= req.data;
        end
        if (advance && in_valid_reg)
        begin
            out_data_reg <= calc_res;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;
endmodule
